### rtl/acfr_pkg.sv
`default_nettype none
package acfr_pkg;

  localparam logic [7:0] StartFirst = 8'hAA;
  localparam logic [7:0] StartLast  = 8'h55;
  localparam logic [7:0] StopFirst  = 8'h55;
  localparam logic [7:0] StopLast   = 8'hAA;
  localparam logic [7:0] BoardAddrReset = 8'h3F;

  localparam int unsigned NumPayload = 4;

  localparam logic RegBoardAddr = 1'b0;

  typedef enum logic [2:0] {
    PH_HUNT_EMPTY = 3'd0,
    PH_HUNT_HELD  = 3'd1,
    PH_ADDRESS    = 3'd2,
    PH_PAYLOAD    = 3'd3,
    PH_STOP_FIRST = 3'd4,
    PH_STOP_LAST  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0]  command_flag;
    logic [7:0]  register_number;
    logic [15:0] data_word;
    logic        checksum_ok;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } result_t;

endpackage
`default_nettype wire

### rtl/acfr_rx_if.sv
`default_nettype none
interface acfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

### rtl/acfr_cmd_if.sv
`default_nettype none
interface acfr_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  command_flag;
  logic [7:0]  register_number;
  logic [15:0] data_word;
  logic        checksum_ok;

  modport source (output valid, output command_flag, output register_number,
                  output data_word, output checksum_ok, input ready);
  modport sink   (input valid, input command_flag, input register_number,
                  input data_word, input checksum_ok, output ready);
endinterface
`default_nettype wire

### rtl/acfr_framer.sv
`default_nettype none
module acfr_framer
  import acfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] board_addr_i,
  output result_t         res_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] held_start_q, held_start_d;
  logic [7:0] held_stop_q, held_stop_d;
  logic [1:0] count_q, count_d;
  logic [7:0] payload_q [NumPayload];
  logic       pay_we;
  logic [7:0] x;
  logic [3:0] bip;

  // next state
  always_comb begin
    phase_d      = phase_q;
    held_start_d = held_start_q;
    held_stop_d  = held_stop_q;
    count_d      = count_q;
    pay_we       = 1'b0;
    case (phase_q)
      PH_HUNT_HELD: begin
        if (held_start_q == StartFirst && byte_i == StartLast) begin
          held_start_d = 8'h00;
          phase_d      = PH_ADDRESS;
        end else begin
          held_start_d = byte_i;
        end
      end
      PH_ADDRESS: begin
        if (byte_i == board_addr_i) begin
          count_d = 2'd0;
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d = PH_HUNT_EMPTY;
        end
      end
      PH_PAYLOAD: begin
        pay_we  = 1'b1;
        count_d = count_q + 2'd1;
        if (count_q == 2'd3) begin
          phase_d = PH_STOP_FIRST;
        end
      end
      PH_STOP_FIRST: begin
        held_stop_d = byte_i;
        phase_d     = PH_STOP_LAST;
      end
      PH_STOP_LAST: begin
        held_stop_d = 8'h00;
        phase_d     = PH_HUNT_EMPTY;
      end
      default: begin
        held_start_d = byte_i;
        phase_d      = PH_HUNT_HELD;
      end
    endcase
  end

  // result
  always_comb begin
    x = {4'h0, payload_q[0][3:0]} ^ payload_q[1] ^ payload_q[2] ^ payload_q[3];
    bip = x[7:4] ^ x[3:0];
    res_o.valid = en_i && (phase_q == PH_STOP_LAST) && (held_stop_q == StopFirst)
                  && (byte_i == StopLast);
    res_o.cmd.command_flag    = payload_q[0];
    res_o.cmd.register_number = payload_q[1];
    res_o.cmd.data_word       = {payload_q[2], payload_q[3]};
    res_o.cmd.checksum_ok     = (bip == payload_q[0][7:4]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT_EMPTY;
      held_start_q <= 8'h00;
      held_stop_q  <= 8'h00;
      count_q      <= 2'd0;
    end else if (en_i) begin
      phase_q      <= phase_d;
      held_start_q <= held_start_d;
      held_stop_q  <= held_stop_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && pay_we) begin
      payload_q[count_q] <= byte_i;
    end
  end

endmodule
`default_nettype wire

### rtl/addressed_command_frame_receiver.sv
`default_nettype none
// Addressed command frame receiver. Takes one received byte per word on rx_i
// and assembles frames AA 55 | address | P0 P1 P2 P3 | 55 AA. A frame whose
// address byte differs from the board address register (APB offset 0x0,
// reset 0x3F) is dropped, as is one with a bad stop pair. A good frame
// yields one word on cmd_o in the cycle after its final stop byte is taken:
// P0 as command_flag, P1 as register_number, P2:P3 as data_word, and
// checksum_ok comparing P0[7:4] with the BIP-4 of P0[3:0], P1, P2 and P3.
// One byte is taken per cycle; the only stall is a held command word that
// cmd_o has not yet taken.
module addressed_command_frame_receiver
  import acfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  acfr_rx_if.sink          rx_i,
  acfr_cmd_if.source       cmd_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [7:0] board_addr_q;
  logic       out_valid_q;
  cmd_t       out_cmd_q;
  logic       accept;
  result_t    res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegBoardAddr) ? {24'h0, board_addr_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_addr_q <= BoardAddrReset;
    end else if (psel && penable && pwrite && paddr[2] == RegBoardAddr) begin
      board_addr_q <= pwdata[7:0];
    end
  end

  assign rx_i.ready = !out_valid_q || cmd_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  acfr_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .byte_i       (rx_i.rx_byte),
    .board_addr_i (board_addr_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_cmd_q <= res.cmd;
    end
  end

  assign cmd_o.valid           = out_valid_q;
  assign cmd_o.command_flag    = out_cmd_q.command_flag;
  assign cmd_o.register_number = out_cmd_q.register_number;
  assign cmd_o.data_word       = out_cmd_q.data_word;
  assign cmd_o.checksum_ok     = out_cmd_q.checksum_ok;

endmodule
`default_nettype wire
